@@ src/mec_pkg.sv @@
package mec_pkg;

  // Field and register widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 13;

  // Reset values of the registers
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(800);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(600);
  localparam logic [CNT_W-1:0] LIMIT_RST  = CNT_W'(42);

  // Q4.FRAC_BITS datapath
  localparam int Q_W     = FRAC_BITS + 4;
  localparam int DIV_W   = COORD_BITS + FRAC_BITS;   // dividend / quotient
  localparam int PROD_W  = 2 * Q_W;                  // exact magnitude product
  localparam int TRUNC_W = PROD_W - FRAC_BITS;       // product after truncation
  localparam int TERM_W  = TRUNC_W + 1;              // signed truncated product
  localparam int SUM_W   = TRUNC_W + 3;              // update sums
  localparam int MAP_W   = DIV_W + 1;                // quotient minus offset
  localparam int SAT_W   = (MAP_W > SUM_W) ? MAP_W : SUM_W;
  localparam int STEP_W  = $clog2(DIV_W);

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  // 1.5 and 0.5 in Q format
  localparam logic [MAP_W-1:0] RE_OFFSET = MAP_W'(3) << (FRAC_BITS - 1);
  localparam logic [MAP_W-1:0] IM_OFFSET = MAP_W'(1) << (FRAC_BITS - 1);

  // |z|^2 escape bound, 4.0
  localparam logic [TRUNC_W:0] ESC_BOUND = (TRUNC_W+1)'(4) << FRAC_BITS;

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_ITERATION_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic start;     // load dividends, clear dividers
    logic div_step;  // one quotient bit per lane
    logic map_c;     // form c, clear z and count
    logic mul;       // register the three products
    logic update;    // z = z*z + c, count + 1
    logic load_out;  // copy count to result register
  } mec_cmd_t;

  typedef struct packed {
    logic at_limit;  // count >= iteration_limit
    logic escaped;   // re^2 + im^2 >= 4
  } mec_sts_t;

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/mec_pixel_if.sv @@
interface mec_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [mec_pkg::COORD_BITS-1:0]  pixel_x;
  logic [mec_pkg::COORD_BITS-1:0]  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ src/mec_count_if.sv @@
interface mec_count_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::CNT_W-1:0]  iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

@@ src/mec_div_lane.sv @@
module mec_div_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [mec_pkg::DIV_W-1:0] dividend,
  input  logic [mec_pkg::DIM_W-1:0] divisor,
  output logic [mec_pkg::DIV_W-1:0] quotient
);
  import mec_pkg::*;

  // Restoring division, one bit per step; quotient shifts in behind dividend.
  logic [DIM_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIM_W-1:0] dvs;
  logic [DIM_W:0]   trial;
  logic             fits;

  assign dvs   = (divisor == '0) ? DIM_W'(1) : divisor;
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= fits ? DIM_W'(trial - {1'b0, dvs}) : trial[DIM_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;
endmodule

@@ src/mec_datapath.sv @@
module mec_datapath (
  input  logic                           clk,
  input  mec_pkg::mec_cmd_t              cmd,
  output mec_pkg::mec_sts_t              sts,
  input  logic [mec_pkg::COORD_BITS-1:0] pixel_x,
  input  logic [mec_pkg::COORD_BITS-1:0] pixel_y,
  input  logic [mec_pkg::DIM_W-1:0]      image_width,
  input  logic [mec_pkg::DIM_W-1:0]      image_height,
  input  logic [mec_pkg::CNT_W-1:0]      iteration_limit,
  output logic [mec_pkg::CNT_W-1:0]      iteration_count
);
  import mec_pkg::*;

  logic [DIV_W-1:0]        quo_x;
  logic [DIV_W-1:0]        quo_y;
  q_t                      c_re;
  q_t                      c_im;
  q_t                      zr;
  q_t                      zi;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        result;
  logic [Q_W-1:0]          mag_re;
  logic [Q_W-1:0]          mag_im;
  logic [PROD_W-1:0]       prod_rr;
  logic [PROD_W-1:0]       prod_ii;
  logic [PROD_W-1:0]       prod_ri;
  logic                    ri_neg;
  logic [TRUNC_W-1:0]      rr;
  logic [TRUNC_W-1:0]      ii;
  logic [TRUNC_W-1:0]      ri_mag;
  logic signed [TERM_W-1:0] ri_s;
  logic signed [SAT_W-1:0] map_re;
  logic signed [SAT_W-1:0] map_im;
  logic signed [SAT_W-1:0] re_sum;
  logic signed [SAT_W-1:0] im_sum;

  mec_div_lane u_div_x (
    .clk      (clk),
    .load     (cmd.start),
    .step     (cmd.div_step),
    .dividend ({pixel_x, {FRAC_BITS{1'b0}}}),
    .divisor  (image_width),
    .quotient (quo_x)
  );

  mec_div_lane u_div_y (
    .clk      (clk),
    .load     (cmd.start),
    .step     (cmd.div_step),
    .dividend ({pixel_y, {FRAC_BITS{1'b0}}}),
    .divisor  (image_height),
    .quotient (quo_y)
  );

  assign map_re = $signed(SAT_W'(quo_x)) - $signed(SAT_W'(RE_OFFSET));
  assign map_im = $signed(SAT_W'(quo_y)) - $signed(SAT_W'(IM_OFFSET));

  // Sign-magnitude multiply: magnitudes in, truncate, sign back on.
  assign mag_re = zr[Q_W-1] ? Q_W'(-zr) : Q_W'(zr);
  assign mag_im = zi[Q_W-1] ? Q_W'(-zi) : Q_W'(zi);

  assign rr     = TRUNC_W'(prod_rr >> FRAC_BITS);
  assign ii     = TRUNC_W'(prod_ii >> FRAC_BITS);
  assign ri_mag = TRUNC_W'(prod_ri >> FRAC_BITS);
  assign ri_s   = ri_neg ? -$signed({1'b0, ri_mag}) : $signed({1'b0, ri_mag});

  assign re_sum = $signed(SAT_W'(rr)) - $signed(SAT_W'(ii)) + SAT_W'(c_re);
  assign im_sum = SAT_W'(ri_s) + SAT_W'(ri_s) + SAT_W'(c_im);

  assign sts.escaped  = ({1'b0, rr} + {1'b0, ii}) >= ESC_BOUND;
  assign sts.at_limit = count >= iteration_limit;

  always_ff @(posedge clk) begin
    if (cmd.map_c) begin
      c_re  <= sat_q(map_re);
      c_im  <= sat_q(map_im);
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.update) begin
      zr    <= sat_q(re_sum);
      zi    <= sat_q(im_sum);
      count <= count + 1'b1;
    end
    if (cmd.mul) begin
      prod_rr <= mag_re * mag_re;
      prod_ii <= mag_im * mag_im;
      prod_ri <= mag_re * mag_im;
      ri_neg  <= zr[Q_W-1] ^ zi[Q_W-1];
    end
    if (cmd.load_out) begin
      result <= count;
    end
  end

  assign iteration_count = result;
endmodule

@@ src/mec_ctrl.sv @@
module mec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mec_pkg::mec_cmd_t cmd,
  input  mec_pkg::mec_sts_t sts
);
  import mec_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MAP,
    S_MUL,
    S_UPD,
    S_DONE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] steps;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (steps == STEP_W'(DIV_W - 1)) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_c  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.at_limit) begin
          state_next = S_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.escaped) begin
          state_next = S_DONE;
        end else begin
          cmd.update = 1'b1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        steps <= '0;
      end else if (cmd.div_step) begin
        steps <= steps + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ src/mandelbrot_escape_count_unit.sv @@
// Escape-time counter for one point of the Mandelbrot set.
// pixel (sink): one beat carries pixel_x / pixel_y. The point is
//   c = (pixel_x / image_width - 1.5) + i*(pixel_y / image_height - 0.5)
//   in Q4.28; z = z*z + c is iterated from zero until |z|^2 >= 4 or
//   iteration_limit iterations are done.
// count (source): one beat per pixel with iteration_count.
// cfg_*: write port; cfg_index selects image_width, image_height or
//   iteration_limit. Write only while no pixel is in flight.
// Sequence: restoring division (two lanes, x and y, one quotient bit each per
//   cycle), then c is formed; each iteration tests the limit and registers
//   the products, then does the escape test and update; then the count goes
//   to the result register. One pixel in work at a time; the next is taken
//   once the previous result reaches the output register.
// Reset (rst, synchronous): control idles, output empty, registers go to
//   800 / 600 / 42.
// Stall: a result waits in the output register while count.ready is low; a
//   new pixel is still accepted and worked, holding in its last state until
//   the register frees.
module mandelbrot_escape_count_unit (
  input  logic                          clk,
  input  logic                          rst,
  mec_pixel_if.sink                     pixel,
  mec_count_if.source                   count,
  input  logic                          cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mec_pkg::CFG_W-1:0]     cfg_data
);
  import mec_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [CNT_W-1:0] iteration_limit;
  mec_cmd_t         cmd;
  mec_sts_t         sts;

  // Config registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_RST;
      image_height    <= HEIGHT_RST;
      iteration_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[DIM_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: division, map, iterate, hand off
  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (count.valid),
    .out_ready (count.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Dividers, shared multiply/update datapath, result register
  mec_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_x         (pixel.pixel_x),
    .pixel_y         (pixel.pixel_y),
    .image_width     (image_width),
    .image_height    (image_height),
    .iteration_limit (iteration_limit),
    .iteration_count (count.iteration_count)
  );

  // One pixel in work: an accept closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> !pixel.ready)
    else $error("pixel accepted while previous still in work");

  // Result register never overwritten while a beat is pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!count.valid || count.ready))
    else $error("result overwritten before taken");

  // The count never exceeds the limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count.valid |-> (count.iteration_count <= iteration_limit))
    else $error("iteration count above limit");

  // At most one datapath command at a time: start, div_step, map_c, mul, update, load_out.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.div_step, cmd.map_c, cmd.mul, cmd.update, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule
